[src/u8s_pkg.sv]
// ----------------------------------------------------------------------------
// u8s_pkg
// types and constants shared by the utf-8 byte sanitizer
// ----------------------------------------------------------------------------
package u8s_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned MAX_SEQ     = 4;
	localparam int unsigned HELD_DEPTH  = MAX_SEQ - 1;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_1    = 3'd1;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_string;
	} out_word_t;

	typedef struct packed {
		logic [MAX_SEQ-1:0][7:0] bytes;
		logic [2:0]              count;
		logic                    eos;
	} grp_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = LEN_NONE;
		priority if ((b & ASCII_MASK) == 8'h00) len = LEN_1;
		else if ((b & LEAD2_MASK) == LEAD2_CODE) len = LEN_2;
		else if ((b & LEAD3_MASK) == LEAD3_CODE) len = LEN_3;
		else if ((b & LEAD4_MASK) == LEAD4_CODE) len = LEN_4;
		else len = LEN_NONE;
		return len;
	endfunction

endpackage

[src/u8s_front.sv]
// ----------------------------------------------------------------------------
// u8s_front
// takes input words, tracks the open sequence, emits whole groups
// ----------------------------------------------------------------------------
module u8s_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8s_pkg::in_word_t item,
	output logic              full,
	input  logic              q_full,
	output logic              grp_valid,
	output u8s_pkg::grp_t     grp
);
	import u8s_pkg::*;

	logic [7:0] held_q [HELD_DEPTH];
	logic [7:0] held_d [HELD_DEPTH];
	logic [1:0] cnt_q, cnt_d;
	logic [2:0] need_q, need_d;
	logic [2:0] len;
	logic       is_cont;
	logic       fresh;
	logic       take;

	assign full = q_full;
	assign take = push && !q_full;

	always_comb begin
		len     = lead_length(item.data_byte);
		is_cont = (item.data_byte & CONT_MASK) == CONT_CODE;
		fresh   = 1'b1;
		held_d  = held_q;
		cnt_d   = cnt_q;
		need_d  = need_q;
		grp.bytes = '0;
		grp.count = LEN_NONE;
		grp.eos   = item.last_byte;
		if (need_q != LEN_NONE) begin
			if (is_cont) begin
				fresh = 1'b0;
				if (({1'b0, cnt_q} + 3'd1) >= need_q) begin
					for (int i = 0; i < HELD_DEPTH; i++) begin
						grp.bytes[i] = held_q[i];
					end
					grp.bytes[cnt_q] = item.data_byte;
					grp.count = {1'b0, cnt_q} + 3'd1;
					cnt_d  = 2'd0;
					need_d = LEN_NONE;
				end else begin
					held_d[cnt_q] = item.data_byte;
					cnt_d = cnt_q + 2'd1;
				end
			end else begin
				cnt_d  = 2'd0;
				need_d = LEN_NONE;
			end
		end
		if (fresh) begin
			if (len == LEN_1) begin
				grp.bytes[0] = item.data_byte;
				grp.count = LEN_1;
			end else if (len != LEN_NONE) begin
				held_d[0] = item.data_byte;
				cnt_d  = 2'd1;
				need_d = len;
			end
		end
		if (item.last_byte) begin
			cnt_d  = 2'd0;
			need_d = LEN_NONE;
		end
	end

	assign grp_valid = take && ((grp.count != LEN_NONE) || item.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			need_q <= LEN_NONE;
		end else if (take) begin
			cnt_q  <= cnt_d;
			need_q <= need_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_q <= held_d;
		end
	end

endmodule

[src/u8s_queue.sv]
// ----------------------------------------------------------------------------
// u8s_queue
// short group queue between front and back, first word shown ahead
// ----------------------------------------------------------------------------
module u8s_queue #(
	parameter int unsigned DEPTH = u8s_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  u8s_pkg::grp_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output u8s_pkg::grp_t rd_data,
	output logic          empty
);
	import u8s_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	grp_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = cnt_q == CNT_FULL;
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[src/u8s_back.sv]
// ----------------------------------------------------------------------------
// u8s_back
// splits queued groups into result words behind an output register
// ----------------------------------------------------------------------------
module u8s_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u8s_pkg::grp_t      head,
	input  logic               q_empty,
	output logic               q_rd,
	output logic [1:0]         idx,
	output logic               empty,
	input  logic               pop,
	output u8s_pkg::out_word_t result
);
	import u8s_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	out_word_t  out_q;
	logic       load;
	logic       grp_last;
	out_word_t  word_d;

	assign load     = !out_valid_q || pop;
	assign grp_last = (head.count == LEN_NONE) || (({1'b0, idx_q} + 3'd1) == head.count);
	assign q_rd     = load && !q_empty && grp_last;

	always_comb begin
		word_d.out_byte      = head.bytes[idx_q];
		word_d.has_byte      = head.count != LEN_NONE;
		word_d.end_of_string = head.eos && grp_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= grp_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_q <= word_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;
	assign idx    = idx_q;

endmodule

[src/utf8_byte_sanitizer_top.sv]
// the group of a taken byte is written into the group queue, then into the back end's output register
// one byte taken per cycle while full is low; the back end sends one word per cycle while pop is high
// a group of n valid bytes leaves as n result words, the group queue absorbs bursts
// full follows the group queue, which holds QUEUE_DEPTH groups
// reset clears the open sequence, queue pointers and output valid at once
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_top
// filters a byte stream down to well-formed utf-8 sequences
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_top #(
	parameter int unsigned QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8s_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output u8s_pkg::out_word_t result
);
	import u8s_pkg::*;

	grp_t       grp;
	grp_t       head;
	logic       grp_valid;
	logic       q_full;
	logic       q_empty;
	logic       q_rd;
	logic [1:0] idx;

	u8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.q_full    (q_full),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	u8s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (grp_valid),
		.wr_data (grp),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (head),
		.empty   (q_empty)
	);

	u8s_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.idx     (idx),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		grp_valid |-> !q_full)
		else $error("group written into a full queue");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && head.count != LEN_NONE) |-> ({1'b0, idx} < head.count))
		else $error("word index beyond group length");

	a_idx_zero_on_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && head.count == LEN_NONE) |-> (idx == 2'd0))
		else $error("end marker group entered mid group");

	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.has_byte || result.end_of_string))
		else $error("empty word without end marker");

endmodule

[bench/u8s_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// u8s_checker
// watches both queue sides of the utf-8 byte sanitizer, predicts the result
// words of every accepted input word and compares them in order
// ----------------------------------------------------------------------------
module u8s_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  u8s_pkg::in_word_t  item,
	input  logic               empty,
	input  logic               pop,
	input  u8s_pkg::out_word_t result,
	output int unsigned        fail_count,
	output int unsigned        words_pending
);
	import u8s_pkg::*;

	localparam int unsigned EXP_DEPTH = 1024;

	logic [7:0]  held_seq [3];
	logic [1:0]  held_num;
	logic [2:0]  open_len;
	out_word_t   expected_words [EXP_DEPTH];
	int unsigned exp_wr;
	int unsigned exp_rd;

	function automatic logic [2:0] seq_length(input logic [7:0] b);
		if ((b & ASCII_MASK) == 8'h00) return LEN_1;
		if ((b & LEAD2_MASK) == LEAD2_CODE) return LEN_2;
		if ((b & LEAD3_MASK) == LEAD3_CODE) return LEN_3;
		if ((b & LEAD4_MASK) == LEAD4_CODE) return LEN_4;
		return LEN_NONE;
	endfunction

	function automatic out_word_t pass_word(input logic [7:0] b, input logic has);
		out_word_t w;
		w.out_byte      = b;
		w.has_byte      = has;
		w.end_of_string = 1'b0;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic sanitize_byte(input logic [7:0] b, input logic l);
		out_word_t  burst [MAX_SEQ];
		int         n;
		logic       restart;
		logic [2:0] len;
		int         i;
		n = 0;
		restart = 1'b1;
		if (open_len != LEN_NONE) begin
			if ((b & CONT_MASK) == CONT_CODE) begin
				restart = 1'b0;
				if (int'(held_num) + 1 >= int'(open_len)) begin
					for (i = 0; i < int'(held_num); i++) begin
						burst[n] = pass_word(held_seq[i], 1'b1);
						n++;
					end
					burst[n] = pass_word(b, 1'b1);
					n++;
					held_num = 2'd0;
					open_len = LEN_NONE;
				end else begin
					held_seq[held_num] = b;
					held_num++;
				end
			end else begin
				held_num = 2'd0;
				open_len = LEN_NONE;
			end
		end
		if (restart) begin
			len = seq_length(b);
			if (len == LEN_1) begin
				burst[n] = pass_word(b, 1'b1);
				n++;
			end else if (len != LEN_NONE) begin
				held_seq[0] = b;
				held_num    = 2'd1;
				open_len    = len;
			end
		end
		if (l) begin
			held_num = 2'd0;
			open_len = LEN_NONE;
			if (n == 0) begin
				burst[n] = pass_word(8'h00, 1'b0);
				n++;
			end
			burst[n - 1].end_of_string = 1'b1;
		end
		for (i = 0; i < n; i++) begin
			expected_words[exp_wr % EXP_DEPTH] = burst[i];
			exp_wr++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			held_num = 2'd0;
			open_len = LEN_NONE;
			exp_wr   = 0;
			exp_rd   = 0;
		end else begin
			if (push && !full)
				sanitize_byte(item.data_byte, item.last_byte);
			if (pop && !empty) begin
				if (exp_wr == exp_rd) begin
					report_mismatch("unexpected word, out_byte", result.out_byte, 8'h00);
				end else begin
					want = expected_words[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (result.out_byte !== want.out_byte)
						report_mismatch("out_byte", result.out_byte, want.out_byte);
					if (result.has_byte !== want.has_byte)
						report_mismatch("has_byte", 8'(result.has_byte), 8'(want.has_byte));
					if (result.end_of_string !== want.end_of_string)
						report_mismatch("end_of_string", 8'(result.end_of_string),
							8'(want.end_of_string));
				end
			end
		end
		words_pending = exp_wr - exp_rd;
	end

endmodule

[bench/tb_utf8_byte_sanitizer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_sanitizer_top
// drives byte strings into the utf-8 byte sanitizer: a directed run over
// every lead class, stray and invalid bytes, interrupted and cut-off
// sequences, then mostly well-formed random text under four idling phases;
// the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_utf8_byte_sanitizer_top;
	import u8s_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_WORDS = 105;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_word_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_word_t   result;
	int unsigned fail_count;
	int unsigned words_pending;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned string_left = 5;
	int unsigned words_sent = 0;

	utf8_byte_sanitizer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	u8s_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.item          (item),
		.empty         (empty),
		.pop           (pop),
		.result        (result),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(input logic [7:0] b, input logic l);
		logic busy;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= '{data_byte: b, last_byte: l};
		do begin
			@(negedge clk);
			busy = full;
			@(posedge clk);
		end while (busy);
		words_sent++;
	endtask

	task automatic send_in_string(input logic [7:0] b);
		logic l;
		string_left--;
		l = (string_left == 0) || ($urandom_range(99) < 3);
		if (l)
			string_left = $urandom_range(12, 1);
		send_word(b, l);
	endtask

	task automatic send_random_char();
		int unsigned pick;
		int unsigned len;
		int unsigned conts;
		int unsigned i;
		logic [7:0]  lead;
		pick = $urandom_range(99);
		if (pick < 75 || (pick >= 75 && pick < 85)) begin
			if (pick < 30)      len = 1;
			else if (pick < 45) len = 2;
			else if (pick < 60) len = 3;
			else if (pick < 75) len = 4;
			else                len = $urandom_range(4, 2);
			case (len)
				1: lead = 8'($urandom_range(127));
				2: lead = LEAD2_CODE | 8'($urandom_range(31));
				3: lead = LEAD3_CODE | 8'($urandom_range(15));
				default: lead = LEAD4_CODE | 8'($urandom_range(7));
			endcase
			conts = (pick < 75) ? len - 1 : $urandom_range(len - 2);
			send_in_string(lead);
			for (i = 0; i < conts; i++)
				send_in_string(CONT_CODE | 8'($urandom_range(63)));
		end else if (pick < 93) begin
			send_in_string(8'($urandom_range(255)));
		end else begin
			send_in_string(CONT_CODE | 8'($urandom_range(63)));
		end
	endtask

	initial begin
		int phase;
		int unsigned phase_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_word(8'h00, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'hC2, 1'b0);
		send_word(8'hA9, 1'b0);
		send_word(8'hE2, 1'b0);
		send_word(8'h82, 1'b0);
		send_word(8'hAC, 1'b0);
		send_word(8'hF0, 1'b0);
		send_word(8'h9F, 1'b0);
		send_word(8'h98, 1'b0);
		send_word(8'hBF, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hF8, 1'b0);
		send_word(8'hC3, 1'b0);
		send_word(8'h41, 1'b0);
		send_word(8'hE2, 1'b0);
		send_word(8'h82, 1'b0);
		send_word(8'hF4, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h80, 1'b1);
		send_word(8'hE1, 1'b0);
		send_word(8'h80, 1'b1);
		send_word(8'h80, 1'b1);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				send_random_char();
		end
		send_word(8'h41, 1'b1);
		push <= 1'b0;

		do
			@(negedge clk);
		while (words_pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
src/u8s_pkg.sv
src/u8s_front.sv
src/u8s_queue.sv
src/u8s_back.sv
src/utf8_byte_sanitizer_top.sv
bench/u8s_checker.sv
bench/tb_utf8_byte_sanitizer_top.sv
